### hw/rtl/hcas_pkg.sv
`default_nettype none

package hcas_pkg;

  localparam int SET_DEPTH     = 512;
  localparam int VERTEX_BITS   = 32;
  localparam int ADDR_W        = $clog2(SET_DEPTH);
  localparam int CNT_W         = $clog2(SET_DEPTH + 1);
  localparam int VERTEX_PORT_W = 32;
  localparam int COUNT_PORT_W  = 10;

  // command codes
  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_APPEND = 2'd1;
  localparam logic [1:0] CMD_QUERY  = 2'd2;
  localparam logic [1:0] CMD_CHECK  = 2'd3;

endpackage

`default_nettype wire

### hw/rtl/hypercube_acute_set_checker_top.sv
`default_nettype none

// Hypercube acute-set checker.
// Holds up to SET_DEPTH vertices (VERTEX_BITS wide) in an on-chip store and
// runs one command per transaction: clear, append, query addable, check acute.
// Command channel: a transaction is taken on the rising edge where start is high
// and busy is low; command and vertex are sampled there.
// Result channel: done pulses for one cycle with verdict, member_count and
// status; the receiver cannot stall, so the result must be taken that cycle.
// Short commands: clear, append and any query/check on a set too small to fail
// give their result the cycle after the command, and busy never rises.
// A query on n members runs n(n-1)/2 + n(n-1) pair tests, and a check runs a
// pair test for every apex and each pair of the other members; both test at
// most one pair per cycle, with a store read before each outer member or apex
// (S_LOAD_Q, S_GET_Q) and each middle member (S_LOAD_A, S_GET_A), then a flush.
// The pace is set by the single read port of the store, which feeds the
// one shared AND/compare unit one member per cycle while sweeping.
// Reset clears the member count and the sequencer; the store contents are not
// cleared and their values are used only below the count.
module hypercube_acute_set_checker_top (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               start,
  output logic                              busy,
  input  wire  [1:0]                        command,
  input  wire  [hcas_pkg::VERTEX_PORT_W-1:0] vertex,
  output logic                              done,
  output logic                              verdict,
  output logic [hcas_pkg::COUNT_PORT_W-1:0]  member_count,
  output logic                              status
);
  import hcas_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_LOAD_Q, S_GET_Q, S_LOAD_A, S_GET_A, S_SWEEP, S_FLUSH
  } state_t;

  state_t                 state;
  logic [CNT_W-1:0]       count;
  logic [CNT_W-1:0]       i;       // outer index: first member or apex
  logic [CNT_W-1:0]       j;       // middle index for the acute check
  logic [CNT_W-1:0]       k;       // inner sweep index
  logic [CNT_W-1:0]       j_next;
  logic                   is_check;
  logic                   phase2;
  logic [VERTEX_BITS-1:0] x;
  logic [VERTEX_BITS-1:0] base;
  logic [VERTEX_BITS-1:0] hold;
  logic [VERTEX_BITS-1:0] rd_data;
  logic [ADDR_W-1:0]      rd_addr;
  logic                   chk_valid;
  logic                   chk_fail;
  logic                   fail;
  logic                   accept;
  logic                   sweep_end;

  logic [VERTEX_BITS-1:0] mem [SET_DEPTH];

  assign busy   = (state != S_IDLE);
  assign accept = start && (state == S_IDLE);

  // shared test unit: one pair per cycle during a sweep, on the registered read data
  assign chk_fail  = chk_valid && ((hold & (rd_data ^ base)) == '0);
  assign sweep_end = (k == count - CNT_W'(1));
  assign j_next    = (j + CNT_W'(1) == i) ? j + CNT_W'(2) : j + CNT_W'(1);

  always_comb begin
    unique case (state)
      S_LOAD_Q: rd_addr = i[ADDR_W-1:0];
      S_LOAD_A: rd_addr = j[ADDR_W-1:0];
      default:  rd_addr = k[ADDR_W-1:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept && command == CMD_APPEND && count != CNT_W'(SET_DEPTH)) begin
      mem[count[ADDR_W-1:0]] <= vertex[VERTEX_BITS-1:0];
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      count        <= '0;
      done         <= 1'b0;
      verdict      <= 1'b0;
      status       <= 1'b0;
      member_count <= '0;
      chk_valid    <= 1'b0;
      fail         <= 1'b0;
      is_check     <= 1'b0;
      phase2       <= 1'b0;
    end else begin
      done      <= 1'b0;
      chk_valid <= 1'b0;
      fail      <= (state == S_IDLE) ? 1'b0 : (fail | chk_fail);
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            verdict      <= 1'b0;
            status       <= 1'b0;
            member_count <= COUNT_PORT_W'(count);
            x            <= vertex[VERTEX_BITS-1:0];
            i            <= '0;
            phase2       <= 1'b0;
            unique case (command)
              CMD_CLEAR: begin
                count        <= '0;
                member_count <= '0;
                done         <= 1'b1;
              end
              CMD_APPEND: begin
                done <= 1'b1;
                if (count != CNT_W'(SET_DEPTH)) begin
                  count        <= count + CNT_W'(1);
                  member_count <= COUNT_PORT_W'(count + CNT_W'(1));
                end else begin
                  status <= 1'b1;
                end
              end
              CMD_QUERY: begin
                is_check <= 1'b0;
                if (count < CNT_W'(2)) begin
                  done    <= 1'b1;
                  verdict <= 1'b1;
                end else begin
                  state <= S_LOAD_Q;
                end
              end
              default: begin
                is_check <= 1'b1;
                if (count < CNT_W'(3)) begin
                  done    <= 1'b1;
                  verdict <= 1'b1;
                end else begin
                  state <= S_LOAD_Q;
                end
              end
            endcase
          end
        end
        S_LOAD_Q: state <= S_GET_Q;
        S_GET_Q: begin
          if (is_check) begin
            base  <= rd_data;
            j     <= (i == '0) ? CNT_W'(1) : '0;
            state <= S_LOAD_A;
          end else if (!phase2) begin
            base  <= x;
            hold  <= rd_data ^ x;
            k     <= i + CNT_W'(1);
            state <= S_SWEEP;
          end else begin
            base  <= rd_data;
            hold  <= rd_data ^ x;
            k     <= '0;
            state <= S_SWEEP;
          end
        end
        S_LOAD_A: state <= S_GET_A;
        S_GET_A: begin
          hold  <= rd_data ^ base;
          k     <= j + CNT_W'(1);
          state <= S_SWEEP;
        end
        S_SWEEP: begin
          chk_valid <= (is_check || phase2) ? (k != i) : 1'b1;
          if (!sweep_end) begin
            k <= k + CNT_W'(1);
          end else if (is_check) begin
            if (j_next >= count - CNT_W'(1)) begin
              if (i == count - CNT_W'(1)) begin
                state <= S_FLUSH;
              end else begin
                i     <= i + CNT_W'(1);
                state <= S_LOAD_Q;
              end
            end else begin
              j     <= j_next;
              state <= S_LOAD_A;
            end
          end else if (!phase2) begin
            state <= S_LOAD_Q;
            if (i >= count - CNT_W'(2)) begin
              phase2 <= 1'b1;
              i      <= '0;
            end else begin
              i <= i + CNT_W'(1);
            end
          end else begin
            if (i == count - CNT_W'(1)) begin
              state <= S_FLUSH;
            end else begin
              i     <= i + CNT_W'(1);
              state <= S_LOAD_Q;
            end
          end
        end
        S_FLUSH: begin
          done         <= 1'b1;
          verdict      <= !(fail || chk_fail);
          status       <= 1'b0;
          member_count <= COUNT_PORT_W'(count);
          state        <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(SET_DEPTH))
    else $error("member count beyond store depth");

  a_done_cause: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(accept) || $past(state == S_FLUSH)))
    else $error("result without a command or a finished sweep");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result while still busy");

  a_status_full: assert property (@(posedge clk) disable iff (rst)
    status |-> (count == CNT_W'(SET_DEPTH)))
    else $error("dropped append with room left");

  a_chk_sweep: assert property (@(posedge clk) disable iff (rst)
    chk_valid |-> $past(state == S_SWEEP))
    else $error("pair test outside a sweep");

endmodule

`default_nettype wire
